@@ design/matq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matq_pkg
// Shared types, codes and defaults of the multi-alarm timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package matq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;
    localparam int TIME_W          = 32;
    localparam int EVT_W           = 3;
    localparam int CFG_IDX_W       = 2;

    // Result codes
    localparam logic [EVT_W-1:0] EVT_PERIOD   = 3'd0;
    localparam logic [EVT_W-1:0] EVT_EXPIRED  = 3'd1;
    localparam logic [EVT_W-1:0] EVT_ACCEPTED = 3'd2;
    localparam logic [EVT_W-1:0] EVT_FULL     = 3'd3;
    localparam logic [EVT_W-1:0] EVT_DONE     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_EN  = 2'd2;

    // Input kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_POP,
        ST_INSERT
    } t_state;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [TIME_W-1:0] key;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ design/matq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matq_cell
// One slot of the sorted alarm chain: holds a deadline and an id, and
// takes a new entry, its left neighbor's or its right neighbor's content.
// ----------------------------------------------------------------------------
`default_nettype none

module matq_cell #(
    parameter int INDEX    = 0,
    parameter int DEPTH    = matq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH = matq_pkg::ID_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire matq_pkg::t_cell_ctl     i_ctl,
    input  wire [ID_WIDTH-1:0]           i_new_id,
    input  wire [$clog2(DEPTH+1)-1:0]    i_count,
    input  wire                          i_left_le,
    input  wire [matq_pkg::TIME_W-1:0]   i_left_dl,
    input  wire [ID_WIDTH-1:0]           i_left_id,
    input  wire [matq_pkg::TIME_W-1:0]   i_right_dl,
    input  wire [ID_WIDTH-1:0]           i_right_id,
    output logic                         o_le,
    output logic [matq_pkg::TIME_W-1:0]  o_dl,
    output logic [ID_WIDTH-1:0]          o_id
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [matq_pkg::TIME_W-1:0] r_dl;
    logic [ID_WIDTH-1:0]         r_id;
    logic                        w_occ;

    // Occupied and not later than the new key: the new entry goes behind it
    assign w_occ = CW'(INDEX) < i_count;
    assign o_le  = w_occ && (r_dl <= i_ctl.key);
    assign o_dl  = r_dl;
    assign o_id  = r_id;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (!o_le) begin
                if (i_left_le || INDEX == 0) begin
                    r_dl <= i_ctl.key;
                    r_id <= i_new_id;
                end else begin
                    r_dl <= i_left_dl;
                    r_id <= i_left_id;
                end
            end
        end else if (i_ctl.pop) begin
            r_dl <= i_right_dl;
            r_id <= i_right_id;
        end
    end

endmodule

`default_nettype wire

@@ design/multi_alarm_timer_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_alarm_timer_queue
// Tick-driven alarm multiplexer: a sorted chain of alarm cells plus one
// periodic event, all running on a 32-bit wrapping time base.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_stall  | i_kind, i_delay, i_alarm_id
//  out      | output    | o_out_valid / i_out_stall| o_event_res, o_expired_id,
//           |           |                          | o_deadline, o_last
//  cfg      | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  A start beat is accepted (deadline add), then the insert state does the compare
//  and shift across the whole cell chain at once. A tick beat is accepted, then
//  the period state emits the periodic event when due, the pop state emits one
//  result per expired alarm and then the done marker; one result leaves per
//  cycle while the output is not stalled, set by the single output register.
//  Reset is synchronous and clears time, period state and the fill count;
//  cell contents are not cleared. A stalled output holds the sequencer.
//  One item is in flight at a time; o_in_stall is high until its last beat
//  is loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_alarm_timer_queue #(
    parameter int QUEUE_DEPTH = matq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = matq_pkg::ID_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_kind,
    input  wire [matq_pkg::TIME_W-1:0]       i_delay,
    input  wire [ID_WIDTH-1:0]               i_alarm_id,
    // output channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [matq_pkg::EVT_W-1:0]       o_event_res,
    output logic [ID_WIDTH-1:0]              o_expired_id,
    output logic [matq_pkg::TIME_W-1:0]      o_deadline,
    output logic                             o_last,
    // configuration
    input  wire                              i_cfg_we,
    input  wire [matq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [matq_pkg::TIME_W-1:0]       i_cfg_data
);

    localparam int TW = matq_pkg::TIME_W;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers
    logic [TW-1:0] r_resolution;
    logic [TW-1:0] r_period;
    logic          r_period_en;

    // Time base
    logic [TW-1:0] r_time;
    logic [TW-1:0] r_next_period;

    // Sequencer
    matq_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [TW-1:0]    r_new_dl;
    logic [ID_WIDTH-1:0] r_new_id;

    // Output register
    logic                       r_out_valid;
    logic [matq_pkg::EVT_W-1:0] r_out_res;
    logic [ID_WIDTH-1:0]        r_out_id;
    logic [TW-1:0]              r_out_dl;
    logic                       r_out_last;

    // Cell chain taps
    logic [QUEUE_DEPTH-1:0] w_le;
    logic [TW-1:0]          w_dl [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]    w_id [QUEUE_DEPTH];

    matq_pkg::t_cell_ctl w_ctl;

    logic                       w_in_accept;
    logic                       w_out_free;
    logic                       w_period_due;
    logic                       w_head_due;
    logic                       w_full;
    logic                       w_emit;
    logic [matq_pkg::EVT_W-1:0] w_res;
    logic [ID_WIDTH-1:0]        w_eid;
    logic [TW-1:0]              w_edl;
    logic                       w_elast;

    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_period_due = (r_period != '0) && r_period_en && (r_time >= r_next_period);
    assign w_head_due   = (r_count != '0) && (w_dl[0] <= r_time);
    assign w_full       = r_count == CW'(QUEUE_DEPTH);

    // ------------------------------------------------------------------
    // Cell chain: cell 0 is the head (earliest deadline)
    // ------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                l_left_le;
            logic [TW-1:0]       l_left_dl;
            logic [ID_WIDTH-1:0] l_left_id;
            logic [TW-1:0]       l_right_dl;
            logic [ID_WIDTH-1:0] l_right_id;

            if (g == 0) begin : g_head
                assign l_left_le = 1'b0;
                assign l_left_dl = r_new_dl;
                assign l_left_id = r_new_id;
            end else begin : g_body
                assign l_left_le = w_le[g-1];
                assign l_left_dl = w_dl[g-1];
                assign l_left_id = w_id[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign l_right_dl = w_dl[g];
                assign l_right_id = w_id[g];
            end else begin : g_inner
                assign l_right_dl = w_dl[g+1];
                assign l_right_id = w_id[g+1];
            end

            matq_cell #(
                .INDEX    (g),
                .DEPTH    (QUEUE_DEPTH),
                .ID_WIDTH (ID_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_new_id   (r_new_id),
                .i_count    (r_count),
                .i_left_le  (l_left_le),
                .i_left_dl  (l_left_dl),
                .i_left_id  (l_left_id),
                .i_right_dl (l_right_dl),
                .i_right_id (l_right_id),
                .o_le       (w_le[g]),
                .o_dl       (w_dl[g]),
                .o_id       (w_id[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Sequencer: next state and result selection
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        o_in_stall = r_state != matq_pkg::ST_IDLE;
        w_ctl.ins  = 1'b0;
        w_ctl.pop  = 1'b0;
        w_ctl.key  = r_new_dl;
        w_emit     = 1'b0;
        w_res      = matq_pkg::EVT_DONE;
        w_eid      = '0;
        w_edl      = r_time;
        w_elast    = 1'b0;

        case (r_state)
            matq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == matq_pkg::KIND_START) ?
                              matq_pkg::ST_INSERT : matq_pkg::ST_PERIOD;
                end
            end
            matq_pkg::ST_PERIOD: begin
                // fire the periodic event first when due
                if (w_period_due) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        w_res   = matq_pkg::EVT_PERIOD;
                        n_state = matq_pkg::ST_POP;
                    end
                end else begin
                    n_state = matq_pkg::ST_POP;
                end
            end
            matq_pkg::ST_POP: begin
                // drain expired alarms from the head, then close the tick
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (w_head_due) begin
                        w_res     = matq_pkg::EVT_EXPIRED;
                        w_eid     = w_id[0];
                        w_edl     = w_dl[0];
                        w_ctl.pop = 1'b1;
                    end else begin
                        w_res   = matq_pkg::EVT_DONE;
                        w_elast = 1'b1;
                        n_state = matq_pkg::ST_IDLE;
                    end
                end
            end
            matq_pkg::ST_INSERT: begin
                if (w_out_free) begin
                    w_emit    = 1'b1;
                    w_eid     = r_new_id;
                    w_edl     = r_new_dl;
                    w_elast   = 1'b1;
                    w_res     = w_full ? matq_pkg::EVT_FULL : matq_pkg::EVT_ACCEPTED;
                    w_ctl.ins = !w_full;
                    n_state   = matq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = matq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= matq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Time base, fill count and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution  <= TW'(1);
            r_period      <= '0;
            r_period_en   <= 1'b0;
            r_time        <= '0;
            r_next_period <= '1;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    matq_pkg::CFG_RESOLUTION: r_resolution <= i_cfg_data;
                    matq_pkg::CFG_PERIOD: begin
                        r_period      <= i_cfg_data;
                        r_next_period <= r_time + i_cfg_data;
                    end
                    matq_pkg::CFG_PERIOD_EN:  r_period_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // advance time on a tick beat
            if (w_in_accept && i_kind == matq_pkg::KIND_TICK) begin
                r_time <= r_time + r_resolution;
            end
            if (r_state == matq_pkg::ST_PERIOD && w_emit) begin
                r_next_period <= r_next_period + r_period;
            end
            if (w_ctl.ins) begin
                r_count <= r_count + CW'(1);
            end else if (w_ctl.pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Hold the start request: deadline and id
    always_ff @(posedge i_clk) begin
        if (w_in_accept && i_kind == matq_pkg::KIND_START) begin
            r_new_dl <= r_time + i_delay;
            r_new_id <= i_alarm_id;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_res  <= w_res;
            r_out_id   <= w_eid;
            r_out_dl   <= w_edl;
            r_out_last <= w_elast;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_out_res;
    assign o_expired_id = r_out_id;
    assign o_deadline   = r_out_dl;
    assign o_last       = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_dl[0] <= w_dl[1]))
        else $error("chain head out of deadline order");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state != matq_pkg::ST_IDLE))
        else $error("sequencer idle right after an accepted beat");

    a_no_ins_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins && w_ctl.pop))
        else $error("insert and pop in the same cycle");

endmodule

`default_nettype wire
